FILE: rtl/core/cst_pkg.sv
`default_nettype none
package cst_pkg;

    // Register map (word index, byte address is 4 * index)
    localparam int unsigned REG_W       = 32;
    localparam int unsigned REG_COUNT   = 8;
    localparam int unsigned ADDR_W      = 5;

    typedef enum logic [2:0] {
        REG_ENTRY_0     = 3'd0,
        REG_ENTRY_1     = 3'd1,
        REG_ENTRY_2     = 3'd2,
        REG_ENTRY_3     = 3'd3,
        REG_DEF_TIMEOUT = 3'd4,
        REG_ACK_TIMEOUT = 3'd5,
        REG_RETRY_LIMIT = 3'd6,
        REG_ACK_COMMAND = 3'd7
    } t_reg_idx;

    // Command table entry layout
    localparam int unsigned ENTRY_W      = 28;
    localparam int unsigned ENT_VALID    = 8;
    localparam int unsigned ENT_NEED_ACK = 9;
    localparam int unsigned ENT_NEED_RSP = 10;
    localparam int unsigned ENT_EVENT    = 11;
    localparam int unsigned ENT_TMO_LO   = 12;

    localparam int unsigned ID_W   = 8;
    localparam int unsigned SEQ_W  = 8;
    localparam int unsigned TMR_W  = 16;
    localparam int unsigned ATT_W  = 8;

    // Stream payload widths
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned OUT_USER_W = 3;

    typedef enum logic [1:0] {
        OP_SEND   = 2'd0,
        OP_PACKET = 2'd1,
        OP_TICK   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_SENT     = 3'd0,
        KIND_BUSY     = 3'd1,
        KIND_UNKNOWN  = 3'd2,
        KIND_NOTHING  = 3'd3,
        KIND_ACK      = 3'd4,
        KIND_EVENT    = 3'd5,
        KIND_RESPONSE = 3'd6,
        KIND_TIMEOUT  = 3'd7
    } t_kind;

    typedef struct packed {
        logic               busy;
        logic               acked;
        logic               awaiting;
        logic [SEQ_W-1:0]   pend_seq;
        logic [ID_W-1:0]    pend_cmd;
        logic [ATT_W-1:0]   attempts;
        logic [TMR_W-1:0]   rsp_cnt;
        logic [TMR_W-1:0]   ack_cnt;
    } t_session;

endpackage
`default_nettype wire

FILE: rtl/core/command_session_tracker_core.sv
// A result item appears on the master side in the cycle after its input item is taken.
// Throughput: one item per cycle while the master side takes results; the output register
//   frees as it is taken, so the slave side stays ready while a waiting result is consumed in the same cycle.
// Reset (i_rst_n, synchronous, active low): session idle, sequence counter and all
//   configuration registers cleared, no result pending.
`default_nettype none
module command_session_tracker_core #(
    parameter int unsigned TABLE_ENTRIES = 4
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // Slave side
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] command_id, [15:8] packet_seq, [16] packet_nonempty, [23:17] zero
    input  wire [cst_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] cmd
    input  wire [cst_pkg::IN_USER_W-1:0]    s_axis_tuser,
    // Master side
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // [7:0] out_command, [15:8] out_seq
    output logic [cst_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [2:0] kind
    output logic [cst_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    // Configuration port
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [cst_pkg::ADDR_W-1:0]       paddr,
    input  wire [cst_pkg::REG_W-1:0]        pwdata,
    output logic [cst_pkg::REG_W-1:0]       prdata,
    output logic                            pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [cst_pkg::ENTRY_W-1:0] r_entry [TABLE_ENTRIES];
    logic [cst_pkg::TMR_W-1:0]   r_def_tmo;
    logic [cst_pkg::TMR_W-1:0]   r_ack_tmo;
    logic [cst_pkg::ATT_W-1:0]   r_retry_limit;
    logic [cst_pkg::ID_W-1:0]    r_ack_cmd;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_entry[i] <= '0;
            end
            r_def_tmo     <= '0;
            r_ack_tmo     <= '0;
            r_retry_limit <= '0;
            r_ack_cmd     <= '0;
        end else if (cfg_wr) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (cfg_idx == 3'(i)) begin
                    r_entry[i] <= pwdata[cst_pkg::ENTRY_W-1:0];
                end
            end
            unique case (cst_pkg::t_reg_idx'(cfg_idx))
                cst_pkg::REG_DEF_TIMEOUT: r_def_tmo     <= pwdata[cst_pkg::TMR_W-1:0];
                cst_pkg::REG_ACK_TIMEOUT: r_ack_tmo     <= pwdata[cst_pkg::TMR_W-1:0];
                cst_pkg::REG_RETRY_LIMIT: r_retry_limit <= pwdata[cst_pkg::ATT_W-1:0];
                cst_pkg::REG_ACK_COMMAND: r_ack_cmd     <= pwdata[cst_pkg::ID_W-1:0];
                default: ;  // table entries handled above
            endcase
        end
    end

    // Readback; table slots beyond the built entries read as zero
    always_comb begin
        prdata = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (cfg_idx == 3'(i)) begin
                prdata = cst_pkg::REG_W'(r_entry[i]);
            end
        end
        unique case (cst_pkg::t_reg_idx'(cfg_idx))
            cst_pkg::REG_DEF_TIMEOUT: prdata = cst_pkg::REG_W'(r_def_tmo);
            cst_pkg::REG_ACK_TIMEOUT: prdata = cst_pkg::REG_W'(r_ack_tmo);
            cst_pkg::REG_RETRY_LIMIT: prdata = cst_pkg::REG_W'(r_retry_limit);
            cst_pkg::REG_ACK_COMMAND: prdata = cst_pkg::REG_W'(r_ack_cmd);
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Input field unpack
    // ------------------------------------------------------------------
    cst_pkg::t_op               in_op;
    logic [cst_pkg::ID_W-1:0]   in_id;
    logic [cst_pkg::SEQ_W-1:0]  in_seq;
    logic                       in_nonempty;

    assign in_op       = cst_pkg::t_op'(s_axis_tuser);
    assign in_id       = s_axis_tdata[7:0];
    assign in_seq      = s_axis_tdata[15:8];
    assign in_nonempty = s_axis_tdata[16];

    // ------------------------------------------------------------------
    // Table lookup: parallel compares, lowest valid match wins
    // ------------------------------------------------------------------
    logic                           lk_hit;
    logic [cst_pkg::ENTRY_W-1:0]    lk_entry;

    always_comb begin
        lk_hit   = 1'b0;
        lk_entry = '0;
        // walk from the top so the lowest matching slot is the last to assign
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_entry[i][cst_pkg::ENT_VALID] && r_entry[i][7:0] == in_id) begin
                lk_hit   = 1'b1;
                lk_entry = r_entry[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Session state and per-item update
    // ------------------------------------------------------------------
    cst_pkg::t_session          r_sess, n_sess;
    logic [cst_pkg::SEQ_W-1:0]  r_next_seq, n_next_seq;

    cst_pkg::t_kind             res_kind;
    logic [cst_pkg::ID_W-1:0]   res_cmd;
    logic [cst_pkg::SEQ_W-1:0]  res_seq;

    logic [cst_pkg::TMR_W-1:0]  ent_tmo;
    logic [cst_pkg::TMR_W-1:0]  rsp_dec;
    logic [cst_pkg::TMR_W-1:0]  ack_dec;
    logic                       need_ack;

    assign ent_tmo  = lk_entry[cst_pkg::ENT_TMO_LO +: cst_pkg::TMR_W];
    assign need_ack = lk_entry[cst_pkg::ENT_NEED_ACK];
    // countdowns for the tick path; rsp_dec saturates at zero, ack_dec is used only while ack_cnt is nonzero
    assign rsp_dec  = (r_sess.rsp_cnt != '0) ? r_sess.rsp_cnt - 1'b1 : '0;
    assign ack_dec  = r_sess.ack_cnt - 1'b1;

    always_comb begin
        n_sess     = r_sess;
        n_next_seq = r_next_seq;
        res_kind   = cst_pkg::KIND_NOTHING;
        res_cmd    = '0;
        res_seq    = '0;

        case (in_op)
            cst_pkg::OP_SEND: begin
                if (r_sess.busy) begin
                    res_kind = cst_pkg::KIND_BUSY;
                    res_cmd  = in_id;
                end else if (!lk_hit) begin
                    res_kind = cst_pkg::KIND_UNKNOWN;
                    res_cmd  = in_id;
                end else begin
                    // open the session and hand out the next sequence number
                    n_sess.busy     = 1'b1;
                    n_sess.acked    = ~need_ack;
                    n_sess.awaiting = lk_entry[cst_pkg::ENT_NEED_RSP];
                    n_sess.pend_seq = r_next_seq;
                    n_sess.pend_cmd = in_id;
                    n_sess.attempts = cst_pkg::ATT_W'(1);
                    n_sess.rsp_cnt  = (ent_tmo != '0) ? ent_tmo : r_def_tmo;
                    n_sess.ack_cnt  = need_ack ? r_ack_tmo : '0;
                    n_next_seq      = r_next_seq + 1'b1;
                    res_kind        = cst_pkg::KIND_SENT;
                    res_cmd         = in_id;
                    res_seq         = r_next_seq;
                end
            end

            cst_pkg::OP_PACKET: begin
                if (!in_nonempty) begin
                    res_kind = cst_pkg::KIND_NOTHING;
                end else if (in_id == r_ack_cmd) begin
                    // acknowledge packets bypass the table
                    if (r_sess.busy && in_seq == r_sess.pend_seq) begin
                        res_kind     = cst_pkg::KIND_ACK;
                        res_cmd      = r_sess.pend_cmd;
                        res_seq      = in_seq;
                        n_sess.acked = 1'b1;
                        if (!r_sess.awaiting) begin
                            n_sess = '0;
                        end
                    end
                end else if (lk_hit && lk_entry[cst_pkg::ENT_EVENT]) begin
                    res_kind = cst_pkg::KIND_EVENT;
                    res_cmd  = in_id;
                    res_seq  = in_seq;
                end else if (r_sess.busy && in_seq == r_sess.pend_seq
                             && in_id == r_sess.pend_cmd) begin
                    res_kind = cst_pkg::KIND_RESPONSE;
                    res_cmd  = in_id;
                    res_seq  = in_seq;
                    n_sess   = '0;
                end
            end

            cst_pkg::OP_TICK: begin
                if (r_sess.busy) begin
                    n_sess.rsp_cnt = rsp_dec;
                    if (!r_sess.acked && r_sess.ack_cnt != '0) begin
                        n_sess.ack_cnt = ack_dec;
                        if (ack_dec == '0) begin
                            if (r_sess.attempts < r_retry_limit) begin
                                // count the retry and rearm the ack timer
                                n_sess.attempts = r_sess.attempts + 1'b1;
                                n_sess.ack_cnt  = r_ack_tmo;
                            end else begin
                                res_kind = cst_pkg::KIND_TIMEOUT;
                            end
                        end
                    end
                    if (rsp_dec == '0) begin
                        res_kind = cst_pkg::KIND_TIMEOUT;
                    end
                    if (res_kind == cst_pkg::KIND_TIMEOUT) begin
                        res_cmd = r_sess.pend_cmd;
                        res_seq = r_sess.pend_seq;
                        n_sess  = '0;
                    end
                end
            end

            default: ;  // no operation
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake and result register
    // ------------------------------------------------------------------
    logic in_take;

    // take a new item whenever the result register is empty or draining
    assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
    assign in_take       = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sess        <= '0;
            r_next_seq    <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (in_take) begin
                r_sess     <= n_sess;
                r_next_seq <= n_next_seq;
            end
            if (in_take) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            m_axis_tdata <= {res_seq, res_cmd};
            m_axis_tuser <= res_kind;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/command_session_tracker_checker.sv
`default_nettype none
module command_session_tracker_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [cst_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input wire [cst_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // every taken item yields a result in the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("taken item gave no result");

    // the slave side only stalls behind a waiting result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("slave side stalled without backpressure");

    // nothing results carry zero command and sequence
    a_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == cst_pkg::KIND_NOTHING |-> m_axis_tdata == '0)
        else $error("nothing result with nonzero payload");

    // refused sends carry no sequence number
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == cst_pkg::KIND_BUSY
                          || m_axis_tuser == cst_pkg::KIND_UNKNOWN)
            |-> m_axis_tdata[15:8] == '0)
        else $error("refused send with nonzero sequence");

endmodule

bind command_session_tracker_core command_session_tracker_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser)
);
`default_nettype wire
